// ===== src/sfq_pkg.sv =====
`timescale 1ns / 1ps

package sfq_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_SORT    = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_RUN,
        S_SORT
    } state_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic enq;
        logic deq;
        logic sort_en;
        logic phase_odd;
    } cell_ctrl_t;

endpackage

// ===== src/sfq_if.sv =====
`timescale 1ns / 1ps

interface sfq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sfq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;

    modport source (output valid, output status, output removed_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input entry_count, output ready);
endinterface

// ===== src/sfq_cell.sv =====
`timescale 1ns / 1ps

module sfq_cell #(
    parameter int INDEX       = 0,
    parameter int QUEUE_DEPTH = 16,
    parameter int CW          = 5
) (
    input  logic                               clk,
    input  sfq_pkg::cell_ctrl_t                ctrl,
    input  logic [CW-1:0]                      occ,
    input  logic signed [sfq_pkg::DATA_W-1:0]  value,
    input  logic signed [sfq_pkg::DATA_W-1:0]  left_data,
    input  logic                               left_gt,
    input  logic signed [sfq_pkg::DATA_W-1:0]  right_data,
    output logic signed [sfq_pkg::DATA_W-1:0]  data,
    output logic                               gt
);
    import sfq_pkg::*;

    localparam logic [CW-1:0] MY_IDX   = CW'(INDEX);
    localparam logic [CW-1:0] NEXT_IDX = CW'(INDEX + 1);
    localparam logic          MY_ODD   = 1'(INDEX % 2);
    localparam logic          HAS_LEFT = (INDEX > 0);
    localparam logic          HAS_RIGHT = (INDEX < QUEUE_DEPTH - 1);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     lo_active;
    logic                     hi_active;

    // Pair roles: lower of (i, i+1) on matching parity, upper otherwise
    assign lo_active = HAS_RIGHT && ctrl.sort_en && (ctrl.phase_odd == MY_ODD)
                       && (NEXT_IDX < occ);
    assign hi_active = HAS_LEFT && ctrl.sort_en && (ctrl.phase_odd != MY_ODD)
                       && (MY_IDX < occ);

    assign gt   = data_reg > right_data;
    assign data = data_reg;

    // Load, shift toward head, or compare-exchange with a neighbor
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.enq && (occ == MY_IDX))
        begin
            data_next = value;
        end
        else if (ctrl.deq)
        begin
            data_next = right_data;
        end
        else if (lo_active && gt)
        begin
            data_next = right_data;
        end
        else if (hi_active && left_gt)
        begin
            data_next = left_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== src/sfq_ctrl.sv =====
`timescale 1ns / 1ps

module sfq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CW          = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sfq_in_if.sink                            req,
    sfq_out_if.source                         rsp,
    input  logic signed [sfq_pkg::DATA_W-1:0] head_data,
    output sfq_pkg::cell_ctrl_t               ctrl,
    output logic [CW-1:0]                     occ
);
    import sfq_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            occ_reg, occ_next;
    logic [CW-1:0]            phase_reg, phase_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] removed_reg, removed_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     accept;
    action_t                  act;

    assign act       = action_t'(req.action);
    assign req.ready = (state_reg == S_RUN) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.entry_count   = COUNT_W'(count_reg);
    assign occ               = occ_reg;

    // Sequencer: one beat per item, sort runs occupancy phases afterward
    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        removed_next   = removed_reg;
        count_next     = count_reg;
        ctrl           = '0;
        ctrl.phase_odd = phase_reg[0];

        unique case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    removed_next   = '0;
                    unique case (act)
                        ACT_ENQUEUE:
                        begin
                            if (occ_reg == DEPTH_C)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.enq = 1'b1;
                                occ_next = occ_reg + ONE_C;
                            end
                        end
                        ACT_DEQUEUE:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.deq     = 1'b1;
                                removed_next = head_data;
                                occ_next     = occ_reg - ONE_C;
                            end
                        end
                        ACT_SORT:
                        begin
                            if (occ_reg > ONE_C)
                            begin
                                state_next = S_SORT;
                                phase_next = '0;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            occ_next = '0;
                        end
                        default:
                        begin
                            occ_next = occ_reg;
                        end
                    endcase
                    count_next = occ_next;
                end
            end
            S_SORT:
            begin
                ctrl.sort_en = 1'b1;
                phase_next   = phase_reg + ONE_C;
                if (phase_reg == occ_reg - ONE_C)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            occ_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        count_reg   <= count_next;
    end

endmodule

// ===== src/sortable_fifo_queue.sv =====
`timescale 1ns / 1ps

// Bounded FIFO of signed 32-bit words held in a row of QUEUE_DEPTH cells, head in cell 0.
// Each accepted beat yields one result; outside a sort a new beat is taken in the cycle
// its predecessor's result is taken. A sort returns its result like the other actions
// (count unchanged), then holds off input while it runs one phase per entry (none for
// zero or one), an odd-even transposition sort in which the even cell pairs and the odd
// cell pairs compare-exchange on alternate cycles. Dequeue shifts the whole row toward
// the head. Entries beyond the count are never read, so the cells need no reset.
module sortable_fifo_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    sfq_in_if.sink    req,
    sfq_out_if.source rsp
);
    import sfq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cell_ctrl_t               ctrl;
    logic [CW-1:0]            occ;
    logic signed [DATA_W-1:0] data [QUEUE_DEPTH];
    logic                     gt   [QUEUE_DEPTH];

    sfq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .head_data (data[0]),
        .ctrl      (ctrl),
        .occ       (occ)
    );

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;
        logic                     left_g;

        if (i == 0)
        begin : g_head
            assign left_d = data[i];
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_d = data[i-1];
            assign left_g = gt[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_d = data[i];
        end
        else
        begin : g_body
            assign right_d = data[i+1];
        end

        sfq_cell #(
            .INDEX       (i),
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .CW          (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occ        (occ),
            .value      (req.value),
            .left_data  (left_d),
            .left_gt    (left_g),
            .right_data (right_d),
            .data       (data[i]),
            .gt         (gt[i])
        );
    end

endmodule

// ===== src/sfq_checker.sv =====
`timescale 1ns / 1ps

module sfq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] removed_value,
    input logic [4:0]  entry_count
);
    import sfq_pkg::*;

    // A held result stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");

    // A new result only follows an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without input beat");

    // Only a good dequeue returns a nonzero word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (removed_value != '0) |-> status == STAT_OK)
        else $error("removed value on failed action");

    // Empty status reports an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_EMPTY) |-> entry_count == '0)
        else $error("empty status with entries held");

    // Count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (QUEUE_DEPTH > 31) || (int'(entry_count) <= QUEUE_DEPTH))
        else $error("entry count above depth");

endmodule

bind sortable_fifo_queue sfq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sfq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .removed_value (rsp.removed_value),
    .entry_count   (rsp.entry_count)
);

// ===== dv/sortable_fifo_queue_tb.sv =====
`timescale 1ns / 1ps

module sortable_fifo_queue_tb;

    import sfq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        status_t                   status;
        logic signed [DATA_W-1:0]  removed;
        logic [COUNT_W-1:0]        count;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sfq_in_if  req_if ();
    sfq_out_if rsp_if ();

    sortable_fifo_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the queue contents, head at index 0
    int            held_q[$];
    queue_result_t expected_q[$];
    queue_result_t want;

    bit src_idle_on   = 1'b0;
    bit sink_stall_on = 1'b0;

    int beats_sent     = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int sort_count     = 0;
    int full_sort_count = 0;
    int full_drops     = 0;
    int empty_reads    = 0;

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Global watchdog
    initial
    begin
        #20_000_000;
        $display("Timeout: %0d beats sent, %0d results pending", beats_sent,
                 expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Ascending signed insertion sort of the shadow queue
    function automatic void sort_held();
        int key;
        int j;
        for (int i = 1; i < held_q.size(); i++)
        begin
            key = held_q[i];
            j   = i;
            while (j > 0 && key < held_q[j-1])
            begin
                held_q[j] = held_q[j-1];
                j--;
            end
            held_q[j] = key;
        end
    endfunction

    // Apply one accepted beat to the shadow queue and queue up its result
    task automatic predict_result(input action_t act, input logic signed [DATA_W-1:0] val);
        queue_result_t r;
        r.status  = STAT_OK;
        r.removed = '0;
        case (act)
            ACT_ENQUEUE:
                if (held_q.size() >= QUEUE_DEPTH)
                begin
                    r.status = STAT_FULL;
                    full_drops++;
                end
                else
                    held_q.push_back(int'(val));
            ACT_DEQUEUE:
                if (held_q.size() == 0)
                begin
                    r.status = STAT_EMPTY;
                    empty_reads++;
                end
                else
                    r.removed = held_q.pop_front();
            ACT_SORT:
            begin
                sort_count++;
                if (held_q.size() == QUEUE_DEPTH)
                    full_sort_count++;
                sort_held();
            end
            default:
                held_q.delete();
        endcase
        r.count = COUNT_W'(held_q.size());
        expected_q.push_back(r);
    endtask

    // Send one beat, with an optional random idle burst in front of it
    task automatic send_op(input action_t act, input logic signed [DATA_W-1:0] val);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.value  <= val;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        beats_sent++;
        predict_result(act, val);
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return int'($urandom_range(0, 16)) - 8;   // dense, many duplicates
            default: return $urandom;
        endcase
    endfunction

    function automatic action_t pick_action(input bit fill_phase);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return ACT_CLEAR;
        else if (roll < 10)
            return ACT_SORT;
        else if (roll < (fill_phase ? 70 : 35))
            return ACT_ENQUEUE;
        else
            return ACT_DEQUEUE;
    endfunction

    // Empty queue: dequeue flags empty, sort and clear do nothing
    task automatic test_empty_queue();
        send_op(ACT_DEQUEUE, 32'sh1234_5678);
        send_op(ACT_SORT, '0);
        send_op(ACT_CLEAR, -1);
    endtask

    // Fill with extreme and duplicate values, overflow, sort a full queue, drain three, then clear
    task automatic test_fill_overflow_sort();
        logic signed [DATA_W-1:0] fill_vals[QUEUE_DEPTH];
        fill_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh5555_5555,
                      32'shAAAA_AAAA, 32'sh7FFF_FFFF, 32'sh8000_0000, -2, 2,
                      32'sh7FFF_FFFE, 32'sh8000_0001, 32'sh0000_FFFF,
                      32'shFFFF_0000, 1};
        foreach (fill_vals[i])
            send_op(ACT_ENQUEUE, fill_vals[i]);
        send_op(ACT_ENQUEUE, 32'sh0BAD_F00D);
        send_op(ACT_SORT, '0);
        repeat (3) send_op(ACT_DEQUEUE, '0);
        send_op(ACT_CLEAR, '0);
    endtask

    // Random traffic in alternating fill and drain phases, with idling on both sides
    task automatic test_random_traffic(input int n_beats);
        bit fill_phase;
        fill_phase    = 1'b1;
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        for (int i = 0; i < n_beats; i++)
        begin
            if (i % 40 == 39)
                fill_phase = ~fill_phase;
            if (i % 300 == 299)
                wait_for_results();
            send_op(pick_action(fill_phase), pick_value());
        end
    endtask

    // Closing stretch with no source idling and no sink stalls
    task automatic test_back_to_back(input int n_beats);
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        for (int i = 0; i < n_beats; i++)
            send_op(pick_action((i / 25) % 2 == 0), pick_value());
    endtask

    // Result sink ready, stalled in random bursts
    initial
    begin
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_stall_on && $urandom_range(0, 4) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result status=%0d removed=%0d count=%0d",
                             $realtime, rsp_if.status, rsp_if.removed_value,
                             rsp_if.entry_count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp_if.status !== want.status || rsp_if.removed_value !== want.removed
                    || rsp_if.entry_count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: result %0d mismatch: status exp %0d got %0d,",
                                 $realtime, results_seen, want.status, rsp_if.status);
                        $display("    removed exp %0d got %0d, count exp %0d got %0d",
                                 want.removed, rsp_if.removed_value, want.count,
                                 rsp_if.entry_count);
                    end
                end
            end
        end
    end

    // Reset, run the tests in turn, then settle and report
    initial
    begin
        rst_n         <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.action <= ACT_ENQUEUE;
        req_if.value  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_overflow_sort();
        test_random_traffic(1200);
        test_back_to_back(425);

        wait_for_results();
        repeat (QUEUE_DEPTH + 4) @(posedge clk);

        $display("Ran %0d beats: %0d sorts (%0d on a full queue), %0d enqueues on full,",
                 beats_sent, sort_count, full_sort_count, full_drops);
        $display("%0d dequeues on empty; %0d results checked, %0d mismatches.",
                 empty_reads, results_seen, mismatch_count);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sfq_pkg.sv
src/sfq_if.sv
src/sfq_cell.sv
src/sfq_ctrl.sv
src/sortable_fifo_queue.sv
src/sfq_checker.sv
dv/sortable_fifo_queue_tb.sv
